// ----- rtl/assert_macros.svh -----
// shared assertion macros, sampled on clk_i with rst_ni low as disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a sampled edge
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/dpm_pkg.sv -----
// ----------------------------------------------------------------------------
// dpm_pkg
// Types and fixed constants of the Magnus dew point unit.
// ----------------------------------------------------------------------------
package dpm_pkg;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic [14:0]        humidity;
  } dpm_in_t;

  typedef struct packed {
    logic signed [15:0] dew_temp;
    logic               invalid;
  } dpm_out_t;

  typedef enum logic {
    CFG_MAGNUS_A = 1'b0,
    CFG_MAGNUS_B = 1'b1
  } cfg_reg_e;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [12:0] MAGNUS_A_RST = 13'd4421;
  localparam logic [15:0] MAGNUS_B_RST = 16'd60851;

  // log2 polynomial and ln 2, all Q.24
  localparam logic [22:0]        C_SQ  = 23'd5785597;
  localparam logic [25:0]        C_LIN = 26'd33968255;
  localparam logic signed [31:0] C_OFF = 32'sd11322567;
  localparam logic [23:0]        C_LN2 = 24'd11629080;

  // floor(x/100) by reciprocal: narrow integer part and fraction part
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int unsigned DIV100_SHIFT = 19;
  localparam logic [27:0] FRAC_RECIP   = 28'd171798692;
  localparam int unsigned FRAC_SHIFT   = 34;

  // first term clamp, 2^46 in Q.24
  localparam logic [47:0] TERM_LIM = 48'h4000_0000_0000;

  localparam logic signed [15:0] DP_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DP_MIN = 16'sh8000;

endpackage

// ----- rtl/dpm_udiv.sv -----
// ----------------------------------------------------------------------------
// dpm_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The remainder is preloaded from rem_i, which must be below den_i.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpm_udiv #(
  parameter int unsigned Q_W   = 48,
  parameter int unsigned DEN_W = 17,
  parameter int unsigned TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [Q_W-1:0]   num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quot_o,
  output logic [TAG_W-1:0] tag_o
);

  logic             vld_q [Q_W];
  logic [DEN_W-1:0] rem_q [Q_W];
  logic [Q_W-1:0]   nq_q  [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [TAG_W-1:0] tag_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   nq_in;
    logic [DEN_W-1:0] den_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_head
      assign vld_in = valid_i;
      assign rem_in = rem_i;
      assign nq_in  = num_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_body
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    // numerator bits leave at the top, quotient bits enter at the bottom
    assign trial = {rem_in, nq_in[Q_W-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        nq_q[k]  <= {nq_in[Q_W-2:0], ge};
        den_q[k] <= den_in;
        tag_q[k] <= tag_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quot_o  = nq_q[Q_W-1];
  assign tag_o   = tag_q[Q_W-1];

  `ASSERT_NEVER(a_rem_range, vld_q[Q_W-1] && den_q[Q_W-1] != '0 && rem_q[Q_W-1] >= den_q[Q_W-1], "final remainder not below divisor")

endmodule

// ----- rtl/dew_point_magnus_unit.sv -----
// ----------------------------------------------------------------------------
// dew_point_magnus_unit: Magnus dew point from temperature and humidity
// Division: done by two bit-per-stage dividers.
// Throughput: one transfer per cycle, the whole pipeline holds while a valid output is stalled.
// Reset: async active low, clears valid bits and loads the default coefficients.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dew_point_magnus_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dpm_pkg::dpm_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dpm_pkg::dpm_out_t                out_data_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [dpm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int S     = 24 - FRAC_BITS;  // shift from outside to Q.24
  localparam int R_W   = 9 + S;           // ratio width
  localparam int Y_W   = 7 + S;           // scaled remainder width
  localparam int N1_W  = 28 + S;          // first numerator magnitude width

  typedef struct packed {
    logic        hum_zero;
    logic        den1_zero;
    logic        q_neg;
    logic [27:0] n_mag;
    logic [16:0] d_mag;
  } carry_t;

  typedef struct packed {
    logic               hum_zero;
    logic               den1_zero;
    logic               q_neg;
    logic signed [31:0] ln;
  } tag1_t;

  typedef struct packed {
    logic hum_zero;
    logic den1_zero;
    logic den2_zero;
    logic num_neg;
    logic q_neg;
    logic ovf;
  } flag_t;

  localparam int TAG1_W = $bits(tag1_t);
  localparam int TAG2_W = $bits(flag_t);

  // coefficients
  logic [12:0] magnus_a_q;
  logic [15:0] magnus_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magnus_a_q <= dpm_pkg::MAGNUS_A_RST;
      magnus_b_q <= dpm_pkg::MAGNUS_B_RST;
    end else if (cfg_we_i) begin
      case (dpm_pkg::cfg_reg_e'(cfg_idx_i))
        dpm_pkg::CFG_MAGNUS_A: magnus_a_q <= cfg_data_i[12:0];
        dpm_pkg::CFG_MAGNUS_B: magnus_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_q;
  dpm_pkg::dpm_out_t out_data_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // stage 1: integer part of humidity/100, a*T, b+T
  logic [27:0]        s1_q100_prod;
  logic signed [28:0] s1_at_d;
  logic signed [17:0] s1_den1_d;
  assign s1_q100_prod = 28'(in_data_i.humidity) * 28'(dpm_pkg::DIV100_RECIP);
  assign s1_at_d   = 29'($signed({1'b0, magnus_a_q})) * 29'(in_data_i.temperature);
  assign s1_den1_d = 18'($signed({1'b0, magnus_b_q})) + 18'(in_data_i.temperature);

  logic               s1_v_q;
  logic [14:0]        s1_hum_q;
  logic [8:0]         s1_q100_q;
  logic signed [28:0] s1_at_q;
  logic signed [17:0] s1_den1_q;

  // stage 2: remainder and magnitudes
  logic [6:0] s2_rem_d;
  carry_t     s2_car_d;
  assign s2_rem_d = 7'(16'(s1_hum_q) - 16'(s1_q100_q) * 16'd100);
  always_comb begin
    s2_car_d.hum_zero  = s1_hum_q == '0;
    s2_car_d.den1_zero = s1_den1_q == '0;
    s2_car_d.q_neg     = s1_at_q[28] ^ s1_den1_q[17];
    s2_car_d.n_mag     = 28'(s1_at_q[28] ? -s1_at_q : s1_at_q);
    s2_car_d.d_mag     = 17'(s1_den1_q[17] ? -s1_den1_q : s1_den1_q);
  end

  logic        s2_v_q;
  logic [6:0]  s2_rem_q;
  logic [8:0]  s2_q100_q;
  carry_t      s2_car_q;

  // stage 3: fraction part, ratio in Q.24
  logic [Y_W+27:0] s3_fprod;
  logic [R_W-1:0]  s3_r_d;
  assign s3_fprod = (Y_W+28)'({s2_rem_q, {S{1'b0}}}) * (Y_W+28)'(dpm_pkg::FRAC_RECIP);
  assign s3_r_d   = {s2_q100_q, s3_fprod[dpm_pkg::FRAC_SHIFT +: S]};

  logic           s3_v_q;
  logic [R_W-1:0] s3_r_q;
  carry_t         s3_car_q;

  // stage 4: leading one
  logic [4:0] s4_msb_d;
  always_comb begin
    s4_msb_d = '0;
    for (int k = 0; k < R_W; k++) begin
      if (s3_r_q[k]) begin
        s4_msb_d = 5'(k);
      end
    end
  end

  logic           s4_v_q;
  logic [R_W-1:0] s4_r_q;
  logic [4:0]     s4_msb_q;
  carry_t         s4_car_q;

  // stage 5: normalize into [1,2)
  logic [R_W+24:0] s5_r_ext;
  logic [24:0]     s5_m_d;
  assign s5_r_ext = (R_W+25)'(s4_r_q);
  always_comb begin
    if (s4_msb_q >= 5'd24) begin
      s5_m_d = 25'(s5_r_ext >> (s4_msb_q - 5'd24));
    end else begin
      s5_m_d = 25'(s5_r_ext << (5'd24 - s4_msb_q));
    end
  end

  logic        s5_v_q;
  logic [24:0] s5_m_q;
  logic [4:0]  s5_msb_q;
  carry_t      s5_car_q;

  // stage 6: square term
  logic [49:0] s6_sq_prod;
  assign s6_sq_prod = 50'(s5_m_q) * 50'(s5_m_q);

  logic        s6_v_q;
  logic [24:0] s6_m_q;
  logic [25:0] s6_m2_q;
  logic [4:0]  s6_msb_q;
  carry_t      s6_car_q;

  // stage 7: polynomial products
  logic        s7_v_q;
  logic [50:0] s7_lin_q;
  logic [48:0] s7_sq_q;
  logic [4:0]  s7_msb_q;
  carry_t      s7_car_q;

  // stage 8: log2 in Q.24
  logic [50:0]        s8_pdiff;
  logic signed [31:0] s8_exp;
  logic signed [31:0] s8_lg2_d;
  assign s8_pdiff = s7_lin_q - 51'(s7_sq_q);
  assign s8_exp   = $signed(32'(s7_msb_q)) - 32'sd25;
  assign s8_lg2_d = (s8_exp <<< 24) + $signed(32'(s8_pdiff[50:24])) - dpm_pkg::C_OFF;

  logic               s8_v_q;
  logic signed [31:0] s8_lg2_q;
  carry_t             s8_car_q;

  // stage 9: scale by ln 2
  logic               s9_v_q;
  logic signed [55:0] s9_prod_q;
  carry_t             s9_car_q;

  // stage 10: truncate toward zero
  logic signed [55:0] s10_biased;
  assign s10_biased = s9_prod_q + (s9_prod_q[55] ? 56'sd16777215 : 56'sd0);

  logic               s10_v_q;
  logic signed [31:0] s10_ln_q;
  carry_t             s10_car_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_hum_q  <= in_data_i.humidity;
      s1_q100_q <= s1_q100_prod[dpm_pkg::DIV100_SHIFT +: 9];
      s1_at_q   <= s1_at_d;
      s1_den1_q <= s1_den1_d;
      s2_rem_q  <= s2_rem_d;
      s2_q100_q <= s1_q100_q;
      s2_car_q  <= s2_car_d;
      s3_r_q    <= s3_r_d;
      s3_car_q  <= s2_car_q;
      s4_r_q    <= s3_r_q;
      s4_msb_q  <= s4_msb_d;
      s4_car_q  <= s3_car_q;
      s5_m_q    <= s5_m_d;
      s5_msb_q  <= s4_msb_q;
      s5_car_q  <= s4_car_q;
      s6_m_q    <= s5_m_q;
      s6_m2_q   <= s6_sq_prod[49:24];
      s6_msb_q  <= s5_msb_q;
      s6_car_q  <= s5_car_q;
      s7_lin_q  <= 51'(s6_m_q) * 51'(dpm_pkg::C_LIN);
      s7_sq_q   <= 49'(s6_m2_q) * 49'(dpm_pkg::C_SQ);
      s7_msb_q  <= s6_msb_q;
      s7_car_q  <= s6_car_q;
      s8_lg2_q  <= s8_lg2_d;
      s8_car_q  <= s7_car_q;
      s9_prod_q <= 56'(s8_lg2_q) * 56'($signed({1'b0, dpm_pkg::C_LN2}));
      s9_car_q  <= s8_car_q;
      s10_ln_q  <= 32'(s10_biased >>> 24);
      s10_car_q <= s9_car_q;
    end
  end

  // first division: a*T*2^S / (b+T)
  tag1_t             d1_tag_in;
  logic              d1_v;
  logic [N1_W-1:0]   d1_quot;
  logic [TAG1_W-1:0] d1_tag_w;
  tag1_t             d1_tag;

  always_comb begin
    d1_tag_in.hum_zero  = s10_car_q.hum_zero;
    d1_tag_in.den1_zero = s10_car_q.den1_zero;
    d1_tag_in.q_neg     = s10_car_q.q_neg;
    d1_tag_in.ln        = s10_ln_q;
  end

  dpm_udiv #(
    .Q_W   (N1_W),
    .DEN_W (17),
    .TAG_W (TAG1_W)
  ) u_div_term (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s10_v_q),
    .rem_i   ('0),
    .num_i   ({s10_car_q.n_mag, {S{1'b0}}}),
    .den_i   (s10_car_q.d_mag),
    .tag_i   (d1_tag_in),
    .valid_o (d1_v),
    .quot_o  (d1_quot),
    .tag_o   (d1_tag_w)
  );

  assign d1_tag = tag1_t'(d1_tag_w);

  // stage 11: clamp and sign of the first term
  logic [47:0]        s11_mag48;
  logic [47:0]        s11_magc;
  logic signed [47:0] s11_term_d;
  assign s11_mag48  = 48'(d1_quot);
  assign s11_magc   = (s11_mag48 > dpm_pkg::TERM_LIM) ? dpm_pkg::TERM_LIM : s11_mag48;
  assign s11_term_d = d1_tag.q_neg ? -$signed(s11_magc) : $signed(s11_magc);

  logic               s11_v_q;
  logic signed [47:0] s11_term_q;
  tag1_t              s11_tag_q;

  // stage 12: alpha
  flag_t s12_flg_d;
  always_comb begin
    s12_flg_d           = '0;
    s12_flg_d.hum_zero  = s11_tag_q.hum_zero;
    s12_flg_d.den1_zero = s11_tag_q.den1_zero;
  end

  logic               s12_v_q;
  logic signed [48:0] s12_alpha_q;
  flag_t              s12_flg_q;

  // stage 13: a - alpha and alpha magnitude
  logic signed [49:0] s13_den2_d;
  assign s13_den2_d = 50'($signed({1'b0, magnus_a_q, {S{1'b0}}})) - 50'(s12_alpha_q);

  logic               s13_v_q;
  logic signed [49:0] s13_den2_q;
  logic               s13_aneg_q;
  logic [47:0]        s13_amag_q;
  flag_t              s13_flg_q;

  // stage 14: b*alpha partial products, divisor magnitude
  flag_t s14_flg_d;
  always_comb begin
    s14_flg_d           = s13_flg_q;
    s14_flg_d.den2_zero = s13_den2_q == '0;
    s14_flg_d.num_neg   = s13_aneg_q && (magnus_b_q != '0);
    s14_flg_d.q_neg     = s13_aneg_q ^ s13_den2_q[49];
  end

  logic        s14_v_q;
  logic [39:0] s14_pp_lo_q;
  logic [39:0] s14_pp_hi_q;
  logic [48:0] s14_dmag_q;
  flag_t       s14_flg_q;

  // stage 15: sum partial products
  logic        s15_v_q;
  logic [63:0] s15_nmag_q;
  logic [48:0] s15_dmag_q;
  flag_t       s15_flg_q;

  // stage 16: quotient overflow test, remainder preload
  logic [48:0] s16_hi;
  logic        s16_ovf;
  flag_t       s16_flg_d;
  assign s16_hi  = 49'(s15_nmag_q[63:17]);
  assign s16_ovf = s16_hi >= s15_dmag_q;
  always_comb begin
    s16_flg_d     = s15_flg_q;
    s16_flg_d.ovf = s16_ovf;
  end

  logic        s16_v_q;
  logic [48:0] s16_rem_q;
  logic [16:0] s16_nlo_q;
  logic [48:0] s16_dmag_q;
  flag_t       s16_flg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s11_term_q  <= s11_term_d;
      s11_tag_q   <= d1_tag;
      s12_alpha_q <= 49'(s11_term_q) + 49'(s11_tag_q.ln);
      s12_flg_q   <= s12_flg_d;
      s13_den2_q  <= s13_den2_d;
      s13_aneg_q  <= s12_alpha_q[48];
      s13_amag_q  <= 48'(s12_alpha_q[48] ? -s12_alpha_q : s12_alpha_q);
      s13_flg_q   <= s12_flg_q;
      s14_pp_lo_q <= 40'(magnus_b_q) * 40'(s13_amag_q[23:0]);
      s14_pp_hi_q <= 40'(magnus_b_q) * 40'(s13_amag_q[47:24]);
      s14_dmag_q  <= 49'(s13_den2_q[49] ? -s13_den2_q : s13_den2_q);
      s14_flg_q   <= s14_flg_d;
      s15_nmag_q  <= 64'(s14_pp_lo_q) + {s14_pp_hi_q, 24'd0};
      s15_dmag_q  <= s14_dmag_q;
      s15_flg_q   <= s14_flg_q;
      s16_rem_q   <= s16_ovf ? '0 : s16_hi;
      s16_nlo_q   <= s15_nmag_q[16:0];
      s16_dmag_q  <= s15_dmag_q;
      s16_flg_q   <= s16_flg_d;
    end
  end

  // second division: b*alpha / (a - alpha), 17 quotient bits
  logic              d2_v;
  logic [16:0]       d2_quot;
  logic [TAG2_W-1:0] d2_tag_w;
  flag_t             d2_tag;

  dpm_udiv #(
    .Q_W   (17),
    .DEN_W (49),
    .TAG_W (TAG2_W)
  ) u_div_dew (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s16_v_q),
    .rem_i   (s16_rem_q),
    .num_i   (s16_nlo_q),
    .den_i   (s16_dmag_q),
    .tag_i   (s16_flg_q),
    .valid_o (d2_v),
    .quot_o  (d2_quot),
    .tag_o   (d2_tag_w)
  );

  assign d2_tag = flag_t'(d2_tag_w);

  // result select and saturation
  dpm_pkg::dpm_out_t out_d;
  logic [16:0]       neg_quot;
  assign neg_quot = -d2_quot;

  always_comb begin
    out_d.invalid = 1'b1;
    if (d2_tag.hum_zero || d2_tag.den1_zero) begin
      out_d.dew_temp = dpm_pkg::DP_MIN;
    end else if (d2_tag.den2_zero) begin
      out_d.dew_temp = d2_tag.num_neg ? dpm_pkg::DP_MIN : dpm_pkg::DP_MAX;
    end else if (d2_tag.ovf) begin
      out_d.dew_temp = d2_tag.q_neg ? dpm_pkg::DP_MIN : dpm_pkg::DP_MAX;
    end else if (!d2_tag.q_neg) begin
      if (d2_quot > 17'd32767) begin
        out_d.dew_temp = dpm_pkg::DP_MAX;
      end else begin
        out_d.dew_temp = $signed(d2_quot[15:0]);
        out_d.invalid  = 1'b0;
      end
    end else begin
      if (d2_quot > 17'd32768) begin
        out_d.dew_temp = dpm_pkg::DP_MIN;
      end else begin
        out_d.dew_temp = $signed(neg_quot[15:0]);
        out_d.invalid  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_d;
    end
  end

  // valid bits of the hand-written stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      s9_v_q      <= 1'b0;
      s10_v_q     <= 1'b0;
      s11_v_q     <= 1'b0;
      s12_v_q     <= 1'b0;
      s13_v_q     <= 1'b0;
      s14_v_q     <= 1'b0;
      s15_v_q     <= 1'b0;
      s16_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      s8_v_q      <= s7_v_q;
      s9_v_q      <= s8_v_q;
      s10_v_q     <= s9_v_q;
      s11_v_q     <= d1_v;
      s12_v_q     <= s11_v_q;
      s13_v_q     <= s12_v_q;
      s14_v_q     <= s13_v_q;
      s15_v_q     <= s14_v_q;
      s16_v_q     <= s15_v_q;
      out_valid_q <= d2_v;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_CLK(a_hum_zero_result, en && d2_v && d2_tag.hum_zero |=> out_valid_o && out_data_o.invalid && out_data_o.dew_temp == dpm_pkg::DP_MIN, "zero humidity did not give the invalid minimum")
  `ASSERT_CLK(a_ovf_flagged, en && d2_v && d2_tag.ovf |=> out_valid_o && out_data_o.invalid, "quotient overflow not flagged")
  `ASSERT_CLK(a_stall_holds_out, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of dew_point_magnus_unit
// Random and directed temperature/humidity pairs under several coefficient
// settings, with bursty input and a stalling output. Each result is checked
// against a fixed-point dew point predictor held in the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int FRAC_BITS  = 8;
  localparam int IQ         = 24;
  localparam int SETTLE_CYC = 100;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  dpm_pkg::dpm_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  dpm_pkg::dpm_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  dpm_pkg::cfg_reg_e cfg_idx_i = dpm_pkg::CFG_MAGNUS_A;
  logic [dpm_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  dew_point_magnus_unit #(.FRAC_BITS(FRAC_BITS)) dut (.*);

  always #5 clk_i = ~clk_i;

  logic [12:0] coef_a = dpm_pkg::MAGNUS_A_RST;
  logic [15:0] coef_b = dpm_pkg::MAGNUS_B_RST;

  dpm_pkg::dpm_in_t  samples_pending[$];
  dpm_pkg::dpm_out_t dew_expected[$];
  int errors = 0;
  bit in_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_cyc = 0;
  int idle_cyc = 0;

  // ln(humidity/100) in Q.24, via leading one and a quadratic in the mantissa
  function automatic longint ln_ratio(longint hum);
    longint r, m, m2, p, lg2;
    int msb;
    r = (hum << (IQ - FRAC_BITS)) / 100;
    msb = 0;
    for (int k = 0; k < 40; k++) begin
      if (r[k]) msb = k;
    end
    if (msb >= IQ) m = r >> (msb - IQ);
    else m = r << (IQ - msb);
    m2 = (m * m) >>> IQ;
    p = (longint'(dpm_pkg::C_LIN) * m - longint'(dpm_pkg::C_SQ) * m2) >>> IQ;
    lg2 = (longint'(msb) - IQ - 1) * (longint'(1) << IQ) + p - longint'(dpm_pkg::C_OFF);
    return (lg2 * longint'(dpm_pkg::C_LN2)) / (longint'(1) << IQ);
  endfunction

  function automatic dpm_pkg::dpm_out_t dew_predict(dpm_pkg::dpm_in_t x);
    longint t, hum, a, b, den1, term1, alpha, den2, num, dp;
    longint lim;
    dpm_pkg::dpm_out_t res;
    t = x.temperature;
    hum = x.humidity;
    a = coef_a;
    b = coef_b;
    lim = longint'(1) << 46;
    res.invalid = 1'b0;
    if (hum == 0) begin
      dp = -32768;
      res.invalid = 1'b1;
    end else begin
      den1 = b + t;
      if (den1 == 0) begin
        dp = -32768;
        res.invalid = 1'b1;
      end else begin
        term1 = (a * t * (longint'(1) << (IQ - FRAC_BITS))) / den1;
        if (term1 > lim) term1 = lim;
        if (term1 < -lim) term1 = -lim;
        alpha = term1 + ln_ratio(hum);
        den2 = a * (longint'(1) << (IQ - FRAC_BITS)) - alpha;
        num = b * alpha;
        if (den2 == 0) begin
          dp = (num >= 0) ? 32767 : -32768;
          res.invalid = 1'b1;
        end else begin
          dp = num / den2;
          if (dp > 32767) begin
            dp = 32767;
            res.invalid = 1'b1;
          end else if (dp < -32768) begin
            dp = -32768;
            res.invalid = 1'b1;
          end
        end
      end
    end
    res.dew_temp = dp[15:0];
    return res;
  endfunction

  function automatic dpm_pkg::dpm_in_t sample(int t, int h);
    dpm_pkg::dpm_in_t s;
    s.temperature = t[15:0];
    s.humidity = h[14:0];
    return s;
  endfunction

  function automatic dpm_pkg::dpm_in_t random_sample();
    dpm_pkg::dpm_in_t s;
    if ($urandom_range(9) < 7) begin
      s.temperature = 16'($urandom_range(42240) - 10240);
      s.humidity = 15'($urandom_range(25600, 1));
    end else begin
      s.temperature = 16'($urandom);
      s.humidity = 15'($urandom);
    end
    return s;
  endfunction

  task automatic wait_idle();
    while (samples_pending.size() != 0 || dew_expected.size() != 0 || in_valid_i)
      @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_coefs(logic [15:0] a_val, logic [15:0] b_val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= dpm_pkg::CFG_MAGNUS_A;
    cfg_data_i <= a_val;
    coef_a = a_val[12:0];
    @(negedge clk_i);
    cfg_idx_i <= dpm_pkg::CFG_MAGNUS_B;
    cfg_data_i <= b_val;
    coef_b = b_val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_random(int n);
    repeat (n) samples_pending.push_back(random_sample());
  endtask

  // input driver: bursts with random gaps, payload held while stalled
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (samples_pending.size() != 0) begin
        in_data_i <= samples_pending.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(40, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output stall pattern: free, light and heavy stretches
  always @(negedge clk_i) begin
    if (stall_cyc == 0) begin
      stall_cyc <= $urandom_range(300, 20);
      stall_mode <= $urandom_range(2);
    end else begin
      stall_cyc <= stall_cyc - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(3) == 0);
      default: out_stall_i <= ($urandom_range(3) != 0);
    endcase
  end

  // transfer monitor and checker
  always @(posedge clk_i) begin
    dpm_pkg::dpm_out_t want;
    bit moved;
    moved = 1'b0;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        dew_expected.push_back(dew_predict(in_data_i));
        in_taken = 1'b1;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (dew_expected.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          want = dew_expected.pop_front();
          if (out_data_o.dew_temp !== want.dew_temp) begin
            $error("dew_temp expected %0d actual %0d", want.dew_temp,
                   out_data_o.dew_temp);
            errors++;
          end
          if (out_data_o.invalid !== want.invalid) begin
            $error("invalid expected %0b actual %0b", want.invalid, out_data_o.invalid);
            errors++;
          end
        end
      end
      idle_cyc = moved ? 0 : idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int zero_ln_hum;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // default coefficients: field extremes and the zero humidity case
    samples_pending.push_back(sample(0, 0));
    samples_pending.push_back(sample(-10240, 25600));
    samples_pending.push_back(sample(32000, 1));
    samples_pending.push_back(sample(32767, 32767));
    samples_pending.push_back(sample(-32768, 32767));
    samples_pending.push_back(sample(-32768, 1));
    samples_pending.push_back(sample(-1, 16384));
    samples_pending.push_back(sample(6400, 12800));
    samples_pending.push_back(sample(0, 25600));
    samples_pending.push_back(sample(-5000, 0));
    samples_pending.push_back(sample(5000, 25601));
    push_random(200);

    // b = 0: zero first divisor and, where reachable, a zero second divisor
    wait_idle();
    write_coefs(16'd4421, 16'd0);
    zero_ln_hum = 0;
    for (int h = 1; h < 32768 && zero_ln_hum == 0; h++)
      if (ln_ratio(h) == 0) zero_ln_hum = h;
    samples_pending.push_back(sample(0, 12800));
    if (zero_ln_hum != 0) begin
      samples_pending.push_back(sample(100, zero_ln_hum));
      samples_pending.push_back(sample(-3000, zero_ln_hum));
    end
    push_random(60);

    // b + T = 0 with a small b
    wait_idle();
    write_coefs(16'd0, 16'd1000);
    samples_pending.push_back(sample(-1000, 12800));
    samples_pending.push_back(sample(-999, 12800));
    push_random(80);

    wait_idle();
    write_coefs(16'hFFFF, 16'hFFFF);
    samples_pending.push_back(sample(32767, 32767));
    samples_pending.push_back(sample(-32768, 1));
    push_random(150);

    repeat (3) begin
      wait_idle();
      write_coefs(16'($urandom), 16'($urandom));
      push_random(150);
    end

    wait_idle();
    write_coefs(16'(dpm_pkg::MAGNUS_A_RST), dpm_pkg::MAGNUS_B_RST);
    push_random(100);

    wait_idle();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dpm_pkg.sv
rtl/dpm_udiv.sv
rtl/dew_point_magnus_unit.sv
sim/tb.sv
